### hdl/assert_macros.svh
// Assertion macros shared by the scaler modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define NNS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked at every rising edge outside reset.
`define NNS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NNS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define NNS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### hdl/nns_pkg.sv
// Shared widths, codes and control structs of the nearest-neighbour scaler.
package nns_pkg;

   // field widths
   localparam int PIX_W      = 16;
   localparam int IDX_W      = 22;
   localparam int DIM_W      = 12;
   localparam int POS_W      = 11;
   localparam int OFS_W      = 11;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 12;

   // scaling limits
   localparam int MAX_DIM     = 2048;
   localparam int MAX_UPSCALE = 8;
   localparam int UP_W        = DIM_W + $clog2(MAX_UPSCALE + 1);

   // divider: numerator is a DIM_W x DIM_W product, one quotient bit a cycle
   localparam int PROD_W    = 2 * DIM_W;
   localparam int DIV_CNT_W = $clog2(PROD_W);

   // stream words
   localparam int REQ_TDATA_W = PIX_W;
   localparam int RSP_TDATA_W = ((IDX_W + PIX_W + 7) / 8) * 8;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_SRC_HEIGHT  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_AREA_LEFT   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_AREA_TOP    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_AREA_COLS   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_AREA_ROWS   = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_DEST_STRIDE = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_DEST_ROWS   = 3'd7;

   // bound computations run by the shared divider, in this order
   localparam logic [1:0] OP_ROW_LO = 2'd0;
   localparam logic [1:0] OP_ROW_HI = 2'd1;
   localparam logic [1:0] OP_COL_LO = 2'd2;
   localparam logic [1:0] OP_COL_HI = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic       accept;
      logic       mul;
      logic       div_load;
      logic       div_step;
      logic       store;
      logic [1:0] op;
      logic       loop_init;
      logic       row_calc;
      logic       emit;
      logic       emit_err;
      logic       advance;
   } nns_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic cfg_ok;
      logic rows_left;
      logic cols_any;
      logic col_last;
      logic row_last;
      logic out_free;
   } nns_stat_type;

endpackage

### hdl/nearest_neighbor_rgb565_scaler.sv
// Top level of the nearest-neighbour RGB565 scaler: controller and datapath.
//
//  channel | dir | handshake          | contents
//  req     | in  | tvalid / tready    | tdata: pixel[15:0]; tuser: frame_start
//  rsp     | out | tvalid / tready    | tdata: write_index, write_pixel; tlast; tuser: error
//  csr     | in  | we (no wait)       | addr: register index; wdata: value
//
// One source word at a time. After acceptance the item passes a check state, then its
// four mapping bounds (one shared restoring divider, one quotient bit a cycle; multiply,
// load, divide and store states per bound), then a row state per destination row it
// covers, its writes and a closing row state that steps the source position. An
// invalid configuration gives its error word from the error state instead.
// Reset is synchronous; rsp stalls hold the write loop, and a new source word is
// taken while the final write of the previous one still waits in the output register.
module nearest_neighbor_rgb565_scaler (
   input  logic                              clock,
   input  logic                              reset,
   // source pixels
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [nns_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [15:0] pixel
   input  logic                              req_tuser,  // [0] frame_start
   // destination writes
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [nns_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // [21:0] write_index, [37:22] write_pixel
   output logic                              rsp_tlast,
   output logic                              rsp_tuser,  // [0] config_error
   // configuration
   input  logic                              csr_we,
   input  logic [nns_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [nns_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import nns_pkg::*;

   nns_cmd_type  cmd;
   nns_stat_type stat;

   // sequencer
   nns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd_o      (cmd),
      .stat_i     (stat)
   );

   // registers, divider and output word
   nns_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .cmd_i      (cmd),
      .stat_o     (stat)
   );

endmodule

### hdl/nns_ctrl.sv
// Sequencing state machine of the scaler: bounds, row and write loops.
`include "assert_macros.svh"

module nns_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output nns_pkg::nns_cmd_type  cmd_o,
   input  nns_pkg::nns_stat_type stat_i
);
   import nns_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_ERR   = 4'd2;
   localparam logic [3:0] ST_MUL   = 4'd3;
   localparam logic [3:0] ST_LOAD  = 4'd4;
   localparam logic [3:0] ST_DIV   = 4'd5;
   localparam logic [3:0] ST_STORE = 4'd6;
   localparam logic [3:0] ST_ROW   = 4'd7;
   localparam logic [3:0] ST_EMIT  = 4'd8;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

   logic [3:0]           state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      cmd_o    = '0;
      cmd_o.op = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_o.accept = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!stat_i.cfg_ok) begin
               state_in = ST_ERR;
            end else begin
               op_in    = OP_ROW_LO;
               state_in = ST_MUL;
            end
         end
         ST_ERR: begin
            if (stat_i.out_free) begin
               cmd_o.emit_err = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd_o.mul = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd_o.div_load = 1'b1;
            cnt_in         = '0;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            cmd_o.div_step = 1'b1;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd_o.store = 1'b1;
            if (op_ff == OP_COL_HI) begin
               cmd_o.loop_init = 1'b1;
               state_in        = ST_ROW;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_ROW: begin
            if (stat_i.rows_left && stat_i.cols_any) begin
               cmd_o.row_calc = 1'b1;
               state_in       = ST_EMIT;
            end else begin
               cmd_o.advance = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (stat_i.out_free) begin
               cmd_o.emit = 1'b1;
               if (stat_i.col_last) begin
                  state_in = ST_ROW;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_ROW_LO;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         cnt_ff   <= cnt_in;
      end
   end

   `NNS_ASSERT_IMP(a_emit_has_work, clock, reset, state_ff == ST_EMIT, stat_i.rows_left && stat_i.cols_any, "write loop entered with no write left")
   `NNS_ASSERT_IMP(a_advance_cfg_ok, clock, reset, cmd_o.advance, stat_i.cfg_ok, "position advanced under an invalid configuration")

endmodule

### hdl/nns_dpath.sv
// Datapath of the scaler: registers, position, bound divider, write index and output word.
`include "assert_macros.svh"

module nns_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [nns_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [nns_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [nns_pkg::REQ_TDATA_W-1:0]      req_tdata,
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [nns_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser,
   input  nns_pkg::nns_cmd_type                 cmd_i,
   output nns_pkg::nns_stat_type                stat_o
);
   import nns_pkg::*;

   localparam int ROW_W = DIM_W + 1;

   // configuration registers
   logic [DIM_W-1:0] src_width_ff, src_height_ff, area_cols_ff, area_rows_ff;
   logic [DIM_W-1:0] dest_stride_ff, dest_rows_ff;
   logic [OFS_W-1:0] area_left_ff, area_top_ff;

   // item state
   logic [PIX_W-1:0] pix_ff;
   logic [POS_W-1:0] col_pos_ff, col_pos_in, row_pos_ff, row_pos_in;
   logic [DIM_W-1:0] first_dest_row_ff, first_dest_col_ff, row_hi_ff, col_hi_ff;
   logic [DIM_W-1:0] row_cur_ff, col_cur_ff;
   logic [PROD_W-1:0] prod_ff, num_ff, num_in;
   logic [DIM_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  base_ff;

   // output word
   logic             out_valid_ff;
   logic [IDX_W-1:0] out_index_ff;
   logic [PIX_W-1:0] out_pixel_ff;
   logic             out_last_ff, out_err_ff;

   logic             is_col, hi_bound, div_ge;
   logic [POS_W-1:0] pos_sel;
   logic [DIM_W-1:0] x_sel, a_sel, s_sel, q_clip;
   logic [DIM_W:0]   rem_sh;
   logic [ROW_W-1:0] row_abs;
   logic [2*ROW_W-1:0] row_prod;
   logic [IDX_W-1:0] index_now;

   function automatic logic dim_ok(input logic [DIM_W-1:0] v);
      return (v != '0) && (v <= DIM_W'(MAX_DIM));
   endfunction

   // operand selection for the bound being computed
   always_comb begin
      is_col   = (cmd_i.op == OP_COL_LO) || (cmd_i.op == OP_COL_HI);
      hi_bound = (cmd_i.op == OP_ROW_HI) || (cmd_i.op == OP_COL_HI);
      pos_sel  = is_col ? col_pos_ff : row_pos_ff;
      x_sel    = {1'b0, pos_sel} + DIM_W'(hi_bound);
      a_sel    = is_col ? area_cols_ff : area_rows_ff;
      s_sel    = is_col ? src_width_ff : src_height_ff;
   end

   // restoring divider step: ceil(x*a/s) as (x*a + s - 1) / s
   always_comb begin
      rem_sh = {rem_ff, num_ff[PROD_W-1]};
      div_ge = (rem_sh >= {1'b0, s_sel});
      rem_in = rem_ff;
      num_in = num_ff;
      if (cmd_i.div_load) begin
         rem_in = '0;
         num_in = prod_ff + PROD_W'(s_sel) - PROD_W'(1);
      end else if (cmd_i.div_step) begin
         rem_in = div_ge ? DIM_W'(rem_sh - {1'b0, s_sel}) : rem_sh[DIM_W-1:0];
         num_in = {num_ff[PROD_W-2:0], div_ge};
      end
      q_clip = (num_ff > PROD_W'(a_sel)) ? a_sel : num_ff[DIM_W-1:0];
   end

   // destination row base and write index
   always_comb begin
      row_abs   = ROW_W'(area_top_ff) + ROW_W'(row_cur_ff);
      row_prod  = (2*ROW_W)'(row_abs) * (2*ROW_W)'(dest_stride_ff);
      index_now = base_ff + IDX_W'(area_left_ff) + IDX_W'(col_cur_ff);
   end

   // source position: cleared by frame start, advanced after a valid item
   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (cmd_i.accept && req_tuser) begin
         col_pos_in = '0;
         row_pos_in = '0;
      end else if (cmd_i.advance) begin
         col_pos_in = col_pos_ff + 1'b1;
         if ((DIM_W'(col_pos_in) >= src_width_ff) || (col_pos_in == '0)) begin
            col_pos_in = '0;
            row_pos_in = row_pos_ff + 1'b1;
            if (DIM_W'(row_pos_in) >= src_height_ff) begin
               row_pos_in = '0;
            end
         end
      end
   end

   // status, including the configuration check
   always_comb begin
      stat_o.cfg_ok = dim_ok(src_width_ff) && dim_ok(src_height_ff) &&
                      dim_ok(area_cols_ff) && dim_ok(area_rows_ff) &&
                      (UP_W'(area_cols_ff) <= UP_W'(MAX_UPSCALE) * UP_W'(src_width_ff)) &&
                      (UP_W'(area_rows_ff) <= UP_W'(MAX_UPSCALE) * UP_W'(src_height_ff)) &&
                      ((ROW_W'(area_left_ff) + ROW_W'(area_cols_ff)) <= ROW_W'(dest_stride_ff)) &&
                      ((ROW_W'(area_top_ff) + ROW_W'(area_rows_ff)) <= ROW_W'(dest_rows_ff));
      stat_o.rows_left = (row_cur_ff < row_hi_ff);
      stat_o.cols_any  = (first_dest_col_ff < col_hi_ff);
      stat_o.col_last  = ((ROW_W'(col_cur_ff) + ROW_W'(1)) >= ROW_W'(col_hi_ff));
      stat_o.row_last  = ((ROW_W'(row_cur_ff) + ROW_W'(1)) >= ROW_W'(row_hi_ff));
      stat_o.out_free  = !out_valid_ff || rsp_tready;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff      <= '0;
         src_height_ff     <= '0;
         area_left_ff      <= '0;
         area_top_ff       <= '0;
         area_cols_ff      <= '0;
         area_rows_ff      <= '0;
         dest_stride_ff    <= '0;
         dest_rows_ff      <= '0;
         col_pos_ff        <= '0;
         row_pos_ff        <= '0;
         first_dest_row_ff <= '0;
         first_dest_col_ff <= '0;
         out_valid_ff      <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_SRC_WIDTH:   src_width_ff   <= csr_wdata;
               REG_SRC_HEIGHT:  src_height_ff  <= csr_wdata;
               REG_AREA_LEFT:   area_left_ff   <= csr_wdata[OFS_W-1:0];
               REG_AREA_TOP:    area_top_ff    <= csr_wdata[OFS_W-1:0];
               REG_AREA_COLS:   area_cols_ff   <= csr_wdata;
               REG_AREA_ROWS:   area_rows_ff   <= csr_wdata;
               REG_DEST_STRIDE: dest_stride_ff <= csr_wdata;
               REG_DEST_ROWS:   dest_rows_ff   <= csr_wdata;
               default: ;
            endcase
         end
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         if (cmd_i.store && (cmd_i.op == OP_ROW_LO)) first_dest_row_ff <= q_clip;
         if (cmd_i.store && (cmd_i.op == OP_COL_LO)) first_dest_col_ff <= q_clip;
         if (cmd_i.emit || cmd_i.emit_err) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd_i.accept) pix_ff <= req_tdata[PIX_W-1:0];
      if (cmd_i.mul) prod_ff <= PROD_W'(x_sel) * PROD_W'(a_sel);
      rem_ff <= rem_in;
      num_ff <= num_in;
      if (cmd_i.store && (cmd_i.op == OP_ROW_HI)) row_hi_ff <= q_clip;
      if (cmd_i.store && (cmd_i.op == OP_COL_HI)) col_hi_ff <= q_clip;
      if (cmd_i.loop_init) begin
         row_cur_ff <= first_dest_row_ff;
      end else if (cmd_i.emit && stat_o.col_last) begin
         row_cur_ff <= row_cur_ff + 1'b1;
      end
      if (cmd_i.row_calc) begin
         base_ff    <= row_prod[IDX_W-1:0];
         col_cur_ff <= first_dest_col_ff;
      end else if (cmd_i.emit && !stat_o.col_last) begin
         col_cur_ff <= col_cur_ff + 1'b1;
      end
      if (cmd_i.emit) begin
         out_index_ff <= index_now;
         out_pixel_ff <= pix_ff;
         out_last_ff  <= stat_o.col_last && stat_o.row_last;
         out_err_ff   <= 1'b0;
      end else if (cmd_i.emit_err) begin
         out_index_ff <= '0;
         out_pixel_ff <= '0;
         out_last_ff  <= 1'b1;
         out_err_ff   <= 1'b1;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-IDX_W-PIX_W){1'b0}}, out_pixel_ff, out_index_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_err_ff;

   `NNS_ASSERT_IMP(a_load_slot_free, clock, reset, cmd_i.emit || cmd_i.emit_err, stat_o.out_free, "output word overwritten before it was taken")
   `NNS_ASSERT_NXT(a_pos_hold, clock, reset, !cmd_i.accept && !cmd_i.advance, $stable(col_pos_ff) && $stable(row_pos_ff), "source position moved outside accept or advance")

endmodule

### dv/nearest_neighbor_rgb565_scaler_tb.sv
// Self-checking testbench for the nearest-neighbour RGB565 scaler.
`timescale 1ns / 1ps

module nearest_neighbor_rgb565_scaler_tb;
   import nns_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 10;
   // check, bound search, row and write loops of the busiest word, with margin
   localparam int SETTLE_CYCLES = 250;
   localparam int STALL_LIMIT   = 4000;
   localparam int WRITES_CAP    = 64;

   // one destination write as seen on rsp
   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [PIX_W-1:0] pixel;
      logic             last;
      logic             error;
   } dest_write_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata;   // [15:0] pixel
   logic                    req_tuser;   // [0] frame_start
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;   // [21:0] write_index, [37:22] write_pixel
   logic                    rsp_tlast;
   logic                    rsp_tuser;   // [0] config_error
   logic                    csr_we;
   logic [CSR_ADDR_W-1:0]   csr_addr;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   nearest_neighbor_rgb565_scaler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // scaler geometry as last written
   logic [DIM_W-1:0] src_w, src_h, area_w, area_h, stride, dst_h;
   logic [OFS_W-1:0] area_x, area_y;
   // position of the next source pixel
   logic [POS_W-1:0] col_pos, row_pos;

   dest_write_type pending_writes[$];
   dest_write_type oldest_write;
   int          mismatches = 0;
   int          words_sent;
   int          src_idle_pct;
   int          sink_stall_pct;
   int          quiet_cycles = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   function automatic bit geometry_ok();
      if (src_w == 0 || src_w > MAX_DIM || src_h == 0 || src_h > MAX_DIM) return 1'b0;
      if (area_w == 0 || area_w > MAX_DIM || area_h == 0 || area_h > MAX_DIM) return 1'b0;
      if (int'(area_w) > MAX_UPSCALE * int'(src_w)) return 1'b0;
      if (int'(area_h) > MAX_UPSCALE * int'(src_h)) return 1'b0;
      if (int'(area_x) + int'(area_w) > int'(stride)) return 1'b0;
      if (int'(area_y) + int'(area_h) > int'(dst_h)) return 1'b0;
      return 1'b1;
   endfunction

   // first destination offset whose source coordinate reaches pos: ceil(pos*a/s)
   function automatic longint unsigned dest_bound(longint unsigned pos, longint unsigned a,
                                                  longint unsigned s);
      return (pos * a + s - 1) / s;
   endfunction

   // queue up the writes one source pixel causes and step the source position
   function automatic void predict_writes(logic [PIX_W-1:0] pix, logic frame_start);
      longint unsigned r_lo, r_hi, c_lo, c_hi, r, c, idx;
      int              n;
      dest_write_type  w;
      if (frame_start) begin
         col_pos = '0;
         row_pos = '0;
      end
      if (!geometry_ok()) begin
         w = '{index: '0, pixel: '0, last: 1'b1, error: 1'b1};
         pending_writes.push_back(w);
         return;
      end
      r_lo = dest_bound(row_pos, area_h, src_h);
      r_hi = dest_bound(longint'(row_pos) + 1, area_h, src_h);
      c_lo = dest_bound(col_pos, area_w, src_w);
      c_hi = dest_bound(longint'(col_pos) + 1, area_w, src_w);
      if (r_hi > area_h) r_hi = area_h;
      if (c_hi > area_w) c_hi = area_w;
      n = 0;
      for (r = r_lo; r < r_hi; r++) begin
         for (c = c_lo; c < c_hi; c++) begin
            if (n < WRITES_CAP) begin
               idx = (area_y + r) * stride + area_x + c;
               w = '{index: idx[IDX_W-1:0], pixel: pix, last: 1'b0, error: 1'b0};
               pending_writes.push_back(w);
               n++;
            end
         end
      end
      if (n > 0) pending_writes[$].last = 1'b1;
      // raster advance with wrap
      col_pos = col_pos + 1'b1;
      if (col_pos >= src_w || col_pos == 0) begin
         col_pos = '0;
         row_pos = row_pos + 1'b1;
         if (row_pos >= src_h) row_pos = '0;
      end
   endfunction

   function automatic void log_mismatch(string what, logic [39:0] want, logic [39:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
   endfunction

   // check each accepted write against the oldest one predicted
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            log_mismatch("word with nothing pending", '0, rsp_tdata);
         end else begin
            oldest_write = pending_writes.pop_front();
            if (rsp_tdata[IDX_W-1:0] !== oldest_write.index)
               log_mismatch("write_index", oldest_write.index, rsp_tdata[IDX_W-1:0]);
            if (rsp_tdata[IDX_W+PIX_W-1:IDX_W] !== oldest_write.pixel)
               log_mismatch("write_pixel", oldest_write.pixel, rsp_tdata[IDX_W+PIX_W-1:IDX_W]);
            if (rsp_tlast !== oldest_write.last)
               log_mismatch("last", oldest_write.last, rsp_tlast);
            if (rsp_tuser !== oldest_write.error)
               log_mismatch("config_error", oldest_write.error, rsp_tuser);
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // watchdog: too long without any word moving on either channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // entered and left at a falling edge
   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic frame_start);
      while ($urandom_range(99) < src_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = pix;
      req_tuser  = frame_start;
      do @(posedge clock); while (!req_tready);
      predict_writes(pix, frame_start);
      words_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         REG_SRC_WIDTH:   src_w  = val;
         REG_SRC_HEIGHT:  src_h  = val;
         REG_AREA_LEFT:   area_x = val[OFS_W-1:0];
         REG_AREA_TOP:    area_y = val[OFS_W-1:0];
         REG_AREA_COLS:   area_w = val;
         REG_AREA_ROWS:   area_h = val;
         REG_DEST_STRIDE: stride = val;
         REG_DEST_ROWS:   dst_h  = val;
         default: ;
      endcase
   endtask

   task automatic set_geometry(input int sw, input int sh, input int ax, input int ay,
                               input int aw, input int ah, input int st, input int dh);
      write_reg(REG_SRC_WIDTH,   sw[CSR_DATA_W-1:0]);
      write_reg(REG_SRC_HEIGHT,  sh[CSR_DATA_W-1:0]);
      write_reg(REG_AREA_LEFT,   ax[CSR_DATA_W-1:0]);
      write_reg(REG_AREA_TOP,    ay[CSR_DATA_W-1:0]);
      write_reg(REG_AREA_COLS,   aw[CSR_DATA_W-1:0]);
      write_reg(REG_AREA_ROWS,   ah[CSR_DATA_W-1:0]);
      write_reg(REG_DEST_STRIDE, st[CSR_DATA_W-1:0]);
      write_reg(REG_DEST_ROWS,   dh[CSR_DATA_W-1:0]);
   endtask

   // hold off until every write is out and a word with no writes has surely finished
   task automatic wait_drained();
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic test_error_after_reset();
      send_pixel(16'h1234, 1'b1);
      send_pixel(16'hABCD, 1'b0);
   endtask

   task automatic test_upscale_frame();
      wait_drained();
      set_geometry(2, 2, 2, 1, 3, 3, 9, 6);
      send_pixel(16'h0000, 1'b1);
      send_pixel(16'hFFFF, 1'b0);
      send_pixel(16'hA5A5, 1'b0);
      send_pixel(16'h5A5A, 1'b0);
      // wraps back to the top left
      send_pixel(16'hF800, 1'b0);
   endtask

   task automatic test_downscale_skips();
      wait_drained();
      set_geometry(5, 4, 0, 0, 2, 2, 2, 2);
      send_pixel(16'h07E0, 1'b1);
      send_pixel(16'h001F, 1'b0);
      send_pixel(16'h8410, 1'b0);
      send_pixel(16'h7BEF, 1'b0);
   endtask

   task automatic test_max_upscale();
      wait_drained();
      set_geometry(2, 1, 0, 0, 16, 8, 16, 8);
      send_pixel(16'hC3C3, 1'b1);
      send_pixel(16'h3C3C, 1'b0);
   endtask

   task automatic test_dimension_extremes();
      wait_drained();
      set_geometry(MAX_DIM, MAX_DIM, 0, 0, MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM);
      send_pixel(16'h1111, 1'b1);
      wait_drained();
      // 12-bit writes to the 11-bit offsets: lands on the very last destination pixel
      set_geometry(1, 1, 12'hFFF, 12'hFFF, 1, 1, MAX_DIM, MAX_DIM);
      send_pixel(16'hFFFF, 1'b1);
   endtask

   task automatic test_invalid_geometry();
      wait_drained();
      set_geometry(2, 2, 0, 0, 4, 4, 20, 20);
      write_reg(REG_AREA_COLS, 12'd17);          // upscale beyond the limit
      send_pixel(16'h0F0F, 1'b1);
      wait_drained();
      write_reg(REG_AREA_COLS, 12'd4);
      write_reg(REG_DEST_STRIDE, 12'd3);         // area sticks out to the right
      send_pixel(16'hF0F0, 1'b0);
      wait_drained();
      write_reg(REG_DEST_STRIDE, 12'd20);
      write_reg(REG_DEST_ROWS, 12'd3);           // area sticks out at the bottom
      send_pixel(16'h00FF, 1'b0);
      wait_drained();
      write_reg(REG_DEST_ROWS, 12'd20);
      write_reg(REG_SRC_WIDTH, 12'hFFF);         // above the largest dimension
      send_pixel(16'hFF00, 1'b1);
      wait_drained();
      write_reg(REG_SRC_WIDTH, 12'd2);
      write_reg(REG_AREA_ROWS, 12'd0);           // empty area
      send_pixel(16'h8001, 1'b0);
   endtask

   task automatic test_position_out_of_range();
      wait_drained();
      set_geometry(4, 2, 0, 0, 4, 2, 4, 2);
      send_pixel(16'h1357, 1'b1);
      send_pixel(16'h2468, 1'b0);
      send_pixel(16'h9BDF, 1'b0);
      wait_drained();
      // narrower source mid-frame: column 3 now lies outside
      write_reg(REG_SRC_WIDTH, 12'd2);
      send_pixel(16'hACE0, 1'b0);
      send_pixel(16'hBDF1, 1'b0);
   endtask

   // random geometry, mostly small, valid in half of the picks and broken on purpose in the rest
   task automatic pick_geometry();
      int sw, sh, ax, ay, aw, ah, st, dh;
      sw = $urandom_range(1, 5);
      sh = $urandom_range(1, 4);
      if ($urandom_range(5) == 0) begin
         aw = $urandom_range(1, MAX_UPSCALE * sw);
         ah = $urandom_range(1, MAX_UPSCALE * sh);
      end else begin
         aw = $urandom_range(1, 2 * sw + 1);
         ah = $urandom_range(1, 2 * sh + 1);
      end
      if ($urandom_range(2) == 0) begin
         ax = $urandom_range(0, MAX_DIM - 1 - aw);
         ay = $urandom_range(0, MAX_DIM - 1 - ah);
         st = $urandom_range(ax + aw, MAX_DIM);
         dh = $urandom_range(ay + ah, MAX_DIM);
      end else begin
         ax = $urandom_range(0, 3);
         ay = $urandom_range(0, 3);
         st = ax + aw + $urandom_range(0, 3);
         dh = ay + ah + $urandom_range(0, 3);
      end
      case ($urandom_range(0, 11))
         0: begin
            case ($urandom_range(0, 3))
               0:       sw = 0;
               1:       sh = 0;
               2:       aw = 0;
               default: ah = 0;
            endcase
         end
         1: sw = $urandom_range(MAX_DIM + 1, 4095);
         2: ah = $urandom_range(MAX_DIM + 1, 4095);
         3: aw = MAX_UPSCALE * sw + $urandom_range(1, 3);
         4: st = ax + aw - 1;
         5: dh = ay + ah - 1;
         default: ;
      endcase
      set_geometry(sw, sh, ax, ay, aw, ah, st, dh);
   endtask

   task automatic test_random_frames(input int idle_pct, input int stall_pct, input int count);
      int             goal, len, frame_len, i;
      logic           fs;
      logic [PIX_W-1:0] pix;
      src_idle_pct   = idle_pct;
      sink_stall_pct = stall_pct;
      goal = words_sent + count;
      while (words_sent < goal) begin
         wait_drained();
         pick_geometry();
         frame_len = geometry_ok() ? int'(src_w) * int'(src_h) : 3;
         len = frame_len * $urandom_range(1, 2);
         // cut a frame short now and then
         if ($urandom_range(7) == 0) len = $urandom_range(1, len);
         for (i = 0; i < len && words_sent < goal; i++) begin
            fs = (i % frame_len == 0);
            if ($urandom_range(15) == 0) fs = ~fs;
            pix = PIX_W'($urandom);
            send_pixel(pix, fs);
         end
      end
   endtask

   // sequence of tests
   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = 1'b0;
      csr_we         = 1'b0;
      csr_addr       = '0;
      csr_wdata      = '0;
      src_w = '0; src_h = '0; area_w = '0; area_h = '0; stride = '0; dst_h = '0;
      area_x = '0; area_y = '0; col_pos = '0; row_pos = '0;
      words_sent     = 0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_error_after_reset();
      test_upscale_frame();
      test_downscale_skips();
      test_max_upscale();
      test_dimension_extremes();
      test_invalid_geometry();
      test_position_out_of_range();
      test_random_frames(0, 0, 59);
      test_random_frames(68, 0, 59);
      test_random_frames(0, 68, 59);
      test_random_frames(21, 21, 59);

      wait_drained();
      if (mismatches == 0 && pending_writes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### nearest_neighbor_rgb565_scaler.f
+incdir+hdl
hdl/nns_pkg.sv
hdl/nns_ctrl.sv
hdl/nns_dpath.sv
hdl/nearest_neighbor_rgb565_scaler.sv
dv/nearest_neighbor_rgb565_scaler_tb.sv
